// ===== hw/rtl/assert_macros.svh =====
// assertion helpers shared by the rtl; every check is clocked on clk and
// held off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hw/rtl/iirn4_pkg.sv =====
`default_nettype none

package iirn4_pkg;

    // default parameter values
    localparam int SAMPLE_WIDTH_DEF      = 16;
    localparam int COEF_FRAC_BITS_DEF    = 20;
    localparam int HISTORY_FRAC_BITS_DEF = 8;

    // coefficient word, fixed by the register map
    localparam int COEF_W      = 24;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = COEF_W;

    // register map
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_NUM_OUTER  = 3'd0,
        REG_NUM_INNER  = 3'd1,
        REG_NUM_CENTER = 3'd2,
        REG_DEN_ONE    = 3'd3,
        REG_DEN_TWO    = 3'd4,
        REG_DEN_THREE  = 3'd5,
        REG_DEN_FOUR   = 3'd6
    } cfg_reg_t;

    // coefficient defaults, signed fixed point
    localparam logic signed [COEF_W-1:0] NUM_OUTER_RST  = 24'sd944330;
    localparam logic signed [COEF_W-1:0] NUM_INNER_RST  = -24'sd237856;
    localparam logic signed [COEF_W-1:0] NUM_CENTER_RST = 24'sd1903637;
    localparam logic signed [COEF_W-1:0] DEN_ONE_RST    = -24'sd250077;
    localparam logic signed [COEF_W-1:0] DEN_TWO_RST    = 24'sd1889208;
    localparam logic signed [COEF_W-1:0] DEN_THREE_RST  = -24'sd224716;
    localparam logic signed [COEF_W-1:0] DEN_FOUR_RST   = 24'sd847197;

    // delay line depth on each side
    localparam int TAPS = 4;

endpackage

`default_nettype wire

// ===== hw/rtl/iir_notch_filter_4th_order_core.sv =====
// fourth-order direct-form-I notch filter, one sample per beat
//
// input channel: sample_in with in_valid/in_ready; output channel:
// sample_out and clipped with out_valid/out_ready. a beat moves on a
// rising edge with valid and ready both high.
// config: cfg_we writes cfg_data into register cfg_index in the same
// edge (0..6: num_outer, num_inner, num_center, den_one..den_four);
// index 7 is dropped. write only while the filter is empty.
// path: a sample is held in the input register, then the whole filter
// step runs between that register and the result register.
// throughput: one sample per cycle unless the output stalls; the feedback
// through the output history closes inside that one step, seven
// multiplies feeding one sum.
// stall: the result register holds while out_ready is low, the input
// register still takes one more beat, then in_ready drops until the
// result is taken.
// reset: coefficients return to their defaults, both delay lines and all
// valid flags clear.
// clipped: the stored history or the rounded output was saturated.
`default_nettype none

module iir_notch_filter_4th_order_core #(
    parameter int SAMPLE_WIDTH      = iirn4_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS    = iirn4_pkg::COEF_FRAC_BITS_DEF,
    parameter int HISTORY_FRAC_BITS = iirn4_pkg::HISTORY_FRAC_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // config write port
    input  wire logic                                  cfg_we,
    input  wire logic [iirn4_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [iirn4_pkg::CFG_DATA_W-1:0]      cfg_data,
    // sample input
    input  wire logic                                  in_valid,
    output      logic                                  in_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0]        sample_in,
    // filtered output
    output      logic                                  out_valid,
    input  wire logic                                  out_ready,
    output      logic signed [SAMPLE_WIDTH-1:0]        sample_out,
    output      logic                                  clipped
);

    import iirn4_pkg::*;

    `include "assert_macros.svh"

    // history word width, integer plus fraction
    localparam int HW    = SAMPLE_WIDTH + HISTORY_FRAC_BITS;
    // feedforward sum: three products, two of them of a pre-added pair, plus headroom
    localparam int NUM_W = COEF_W + SAMPLE_WIDTH + 3;
    // full accumulator, wide enough for the feedback terms and the shift
    localparam int ACC_A = COEF_W + HW + 4;
    localparam int ACC_B = HW + COEF_FRAC_BITS + 2;
    localparam int ACC_W = (ACC_A > ACC_B) ? ACC_A : ACC_B;
    localparam int SUM_W = ACC_W - COEF_FRAC_BITS;

    localparam logic [ACC_W-1:0] ROUND_HALF =
        {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
    // zero when the history has no fraction bits
    localparam logic [HW:0] HIST_HALF = ({{HW{1'b0}}, 1'b1} << HISTORY_FRAC_BITS) >> 1;

    // coefficient registers
    logic signed [COEF_W-1:0] num_outer_reg, num_inner_reg, num_center_reg;
    logic signed [COEF_W-1:0] den_one_reg, den_two_reg, den_three_reg, den_four_reg;

    // input register
    logic                            in_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0]  in_sample_reg;

    // delay lines: entry 0 is the newest
    logic signed [SAMPLE_WIDTH-1:0]  x_hist_reg [TAPS];
    logic signed [HW-1:0]            y_hist_reg [TAPS];

    // result register
    logic                            out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0]  sample_out_reg;
    logic                            clipped_reg;

    logic advance;
    logic fire;

    // datapath
    logic signed [SAMPLE_WIDTH:0]          pre_outer, pre_inner;
    logic signed [COEF_W+SAMPLE_WIDTH:0]   prod_outer, prod_inner;
    logic signed [COEF_W+SAMPLE_WIDTH-1:0] prod_center;
    logic signed [NUM_W-1:0]               num_sum;
    logic signed [COEF_W+HW-1:0]           fb_one, fb_two, fb_three, fb_four;
    logic signed [ACC_W-1:0]               acc;
    logic signed [SUM_W-1:0]               sum_q;
    logic                                  hist_hi, hist_lo;
    logic signed [HW-1:0]                  hist_next;
    logic signed [HW:0]                    rnd;
    logic signed [SAMPLE_WIDTH:0]          rnd_q;
    logic                                  out_hi, out_lo;
    logic signed [SAMPLE_WIDTH-1:0]        sample_out_next;
    logic                                  clipped_next;

    // pipeline control: the result register moves when empty or taken
    assign advance   = !out_valid_reg || out_ready;
    assign fire      = in_valid_reg && advance;
    assign in_ready  = !in_valid_reg || advance;

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign clipped    = clipped_reg;

    // symmetric numerator: pre-add the mirrored taps, then three multiplies
    assign pre_outer   = (SAMPLE_WIDTH+1)'(in_sample_reg) + (SAMPLE_WIDTH+1)'(x_hist_reg[3]);
    assign pre_inner   = (SAMPLE_WIDTH+1)'(x_hist_reg[0]) + (SAMPLE_WIDTH+1)'(x_hist_reg[2]);
    assign prod_outer  = num_outer_reg * pre_outer;
    assign prod_inner  = num_inner_reg * pre_inner;
    assign prod_center = num_center_reg * x_hist_reg[1];
    assign num_sum     = NUM_W'(prod_outer) + NUM_W'(prod_inner) + NUM_W'(prod_center);

    // feedback terms against the stored outputs
    assign fb_one   = den_one_reg   * y_hist_reg[0];
    assign fb_two   = den_two_reg   * y_hist_reg[1];
    assign fb_three = den_three_reg * y_hist_reg[2];
    assign fb_four  = den_four_reg  * y_hist_reg[3];

    // numerator aligned to the history fraction, feedback subtracted,
    // half an lsb added for round half up
    assign acc = (ACC_W'(num_sum) <<< HISTORY_FRAC_BITS)
               - ACC_W'(fb_one) - ACC_W'(fb_two) - ACC_W'(fb_three) - ACC_W'(fb_four)
               + signed'(ROUND_HALF);

    // floor shift by the coefficient fraction
    assign sum_q = acc[ACC_W-1:COEF_FRAC_BITS];

    // saturate to the history range
    assign hist_hi = !sum_q[SUM_W-1] && (|sum_q[SUM_W-2:HW-1]);
    assign hist_lo =  sum_q[SUM_W-1] && !(&sum_q[SUM_W-2:HW-1]);

    always_comb
    begin
        priority if (hist_hi)
        begin
            hist_next = {1'b0, {(HW-1){1'b1}}};
        end
        else if (hist_lo)
        begin
            hist_next = {1'b1, {(HW-1){1'b0}}};
        end
        else
        begin
            hist_next = sum_q[HW-1:0];
        end
    end

    // round the history to an integer sample
    assign rnd   = (HW+1)'(hist_next) + signed'(HIST_HALF);
    assign rnd_q = rnd[HW:HISTORY_FRAC_BITS];

    assign out_hi = !rnd_q[SAMPLE_WIDTH] &&  rnd_q[SAMPLE_WIDTH-1];
    assign out_lo =  rnd_q[SAMPLE_WIDTH] && !rnd_q[SAMPLE_WIDTH-1];

    always_comb
    begin
        priority if (out_hi)
        begin
            sample_out_next = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end
        else if (out_lo)
        begin
            sample_out_next = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        end
        else
        begin
            sample_out_next = rnd_q[SAMPLE_WIDTH-1:0];
        end
    end

    assign clipped_next = hist_hi || hist_lo || out_hi || out_lo;

    // coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_outer_reg  <= NUM_OUTER_RST;
            num_inner_reg  <= NUM_INNER_RST;
            num_center_reg <= NUM_CENTER_RST;
            den_one_reg    <= DEN_ONE_RST;
            den_two_reg    <= DEN_TWO_RST;
            den_three_reg  <= DEN_THREE_RST;
            den_four_reg   <= DEN_FOUR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_NUM_OUTER:  num_outer_reg  <= cfg_data;
                REG_NUM_INNER:  num_inner_reg  <= cfg_data;
                REG_NUM_CENTER: num_center_reg <= cfg_data;
                REG_DEN_ONE:    den_one_reg    <= cfg_data;
                REG_DEN_TWO:    den_two_reg    <= cfg_data;
                REG_DEN_THREE:  den_three_reg  <= cfg_data;
                REG_DEN_FOUR:   den_four_reg   <= cfg_data;
                default:
                begin
                    // unmapped index, write dropped
                end
            endcase
        end
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_sample_reg <= sample_in;
        end
    end

    // delay lines advance once per filtered sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                x_hist_reg[i] <= '0;
                y_hist_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            for (int i = TAPS - 1; i > 0; i--)
            begin
                x_hist_reg[i] <= x_hist_reg[i-1];
                y_hist_reg[i] <= y_hist_reg[i-1];
            end
            x_hist_reg[0] <= in_sample_reg;
            y_hist_reg[0] <= hist_next;
        end
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            sample_out_reg <= sample_out_next;
            clipped_reg    <= clipped_next;
        end
    end

    // in_ready only drops with both registers full and the output stalled
    `ASSERT_IMPLIES(a_ready_low_only_when_full, !in_ready,
        in_valid_reg && out_valid_reg && !out_ready)
    // every filter step leaves a result behind
    `ASSERT_NEXT(a_step_gives_result, fire, out_valid_reg)
    // the newest input tap is the sample just filtered
    `ASSERT_NEXT(a_input_tap_loaded, fire, x_hist_reg[0] == $past(in_sample_reg))
    // no step, no change to the newest tap of either delay line or the oldest output tap
    `ASSERT_NEXT(a_hist_hold, !fire,
        $stable(x_hist_reg[0]) && $stable(y_hist_reg[0]) && $stable(y_hist_reg[3]))

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import iirn4_pkg::*;

    // widths and fixed-point formats at the default build
    localparam int SW  = SAMPLE_WIDTH_DEF;
    localparam int CFB = COEF_FRAC_BITS_DEF;
    localparam int HFB = HISTORY_FRAC_BITS_DEF;
    localparam int HW  = SW + HFB;

    localparam longint HIST_MAX = (longint'(1) <<< (HW - 1)) - 1;
    localparam longint HIST_MIN = -HIST_MAX - 1;
    localparam longint OUT_MAX  = (longint'(1) <<< (SW - 1)) - 1;
    localparam longint OUT_MIN  = -OUT_MAX - 1;

    localparam logic signed [SW-1:0]     SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0]     SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [COEF_W-1:0] COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};

    // the one index outside the register map, writes to it are dropped
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    // half an lsb of the stored history: odd samples hit rounding ties
    localparam logic signed [COEF_W-1:0] TIE_TAP = 24'sd2048;

    // input beat to output beat
    localparam int PIPE_LAT    = 2;
    localparam int LONG_HOLD   = 250;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASES      = 9;
    localparam int PHASE_BEATS = 100;

    typedef struct {
        logic signed [SW-1:0] sample;
        logic                 clip;
    } filt_out_t;

    // clock, reset and block ports, all known from time zero
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                          cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0]        cfg_index = REG_NUM_OUTER;
    logic [CFG_DATA_W-1:0]         cfg_data  = '0;
    logic                          in_valid  = 1'b0;
    logic                          in_ready;
    logic signed [SW-1:0]          sample_in = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic signed [SW-1:0]          sample_out;
    logic                          clipped;

    // predictor state: coefficients and both delay lines
    logic signed [COEF_W-1:0] filt_coef [7];
    logic signed [SW-1:0]     x_hist [TAPS];
    logic signed [HW-1:0]     y_hist [TAPS];

    // filtered samples still owed by the block, oldest first
    filt_out_t pending_filtered[$];

    // idling knobs set by the tests
    bit tx_idle_en = 1'b0;
    bit rx_idle_en = 1'b0;

    // long receiver hold-offs: asked by the tests, served by the sink process
    int holds_asked  = 0;
    int holds_served = 0;
    int stall_left   = 0;

    // run statistics
    int errors       = 0;
    int samples_sent = 0;
    int results_seen = 0;
    int clips_seen   = 0;
    int coef_loads   = 0;
    int cycle_count  = 0;

    iir_notch_filter_4th_order_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .clipped    (clipped)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // watchdog on total run length
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still owed", $time, pending_filtered.size());
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic void notch_reset();
        filt_coef[REG_NUM_OUTER]  = NUM_OUTER_RST;
        filt_coef[REG_NUM_INNER]  = NUM_INNER_RST;
        filt_coef[REG_NUM_CENTER] = NUM_CENTER_RST;
        filt_coef[REG_DEN_ONE]    = DEN_ONE_RST;
        filt_coef[REG_DEN_TWO]    = DEN_TWO_RST;
        filt_coef[REG_DEN_THREE]  = DEN_THREE_RST;
        filt_coef[REG_DEN_FOUR]   = DEN_FOUR_RST;
        for (int i = 0; i < TAPS; i++)
        begin
            x_hist[i] = '0;
            y_hist[i] = '0;
        end
    endfunction

    // one filter step: exact sum in 64 bits, round half-up to q.8, saturate,
    // store, then round half-up to an integer and saturate again
    function automatic filt_out_t notch_step(input logic signed [SW-1:0] x);
        longint    acc;
        longint    hist;
        longint    rounded;
        filt_out_t res;
        // palindromic numerator: outer taps on x[n] and x[n-4], inner on n-1 and n-3
        acc = longint'(filt_coef[REG_NUM_OUTER]) * (longint'(x) + longint'(x_hist[3]))
            + longint'(filt_coef[REG_NUM_INNER]) * (longint'(x_hist[0]) + longint'(x_hist[2]))
            + longint'(filt_coef[REG_NUM_CENTER]) * longint'(x_hist[1]);
        acc = acc * (longint'(1) <<< HFB);
        for (int i = 0; i < TAPS; i++)
            acc = acc - longint'(filt_coef[REG_DEN_ONE + i]) * longint'(y_hist[i]);
        acc  = acc + (longint'(1) <<< (CFB - 1));
        hist = acc >>> CFB;
        res.clip = 1'b0;
        if (hist > HIST_MAX)
        begin
            hist     = HIST_MAX;
            res.clip = 1'b1;
        end
        else if (hist < HIST_MIN)
        begin
            hist     = HIST_MIN;
            res.clip = 1'b1;
        end
        for (int i = TAPS - 1; i > 0; i--)
        begin
            x_hist[i] = x_hist[i-1];
            y_hist[i] = y_hist[i-1];
        end
        x_hist[0] = x;
        y_hist[0] = HW'(hist);
        rounded = (hist + (longint'(1) <<< (HFB - 1))) >>> HFB;
        if (rounded > OUT_MAX)
        begin
            rounded  = OUT_MAX;
            res.clip = 1'b1;
        end
        else if (rounded < OUT_MIN)
        begin
            rounded  = OUT_MIN;
            res.clip = 1'b1;
        end
        res.sample = SW'(rounded);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // random helpers
    // ------------------------------------------------------------------

    // idle length: mostly short, now and then a long one
    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            return $urandom_range(1, 3);
        if (pick < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // full-range samples, with small values and the two rails mixed in
    function automatic logic signed [SW-1:0] rand_sample();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return ($urandom_range(0, 1) != 0) ? SAMPLE_MAX : SAMPLE_MIN;
        if (pick < 3)
            return SW'(int'($urandom_range(0, 511)) - 256);
        return SW'($urandom());
    endfunction

    // ------------------------------------------------------------------
    // sink: out_ready with random stalls and the long hold-offs
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (holds_served != holds_asked)
        begin
            // hold off long enough for the block to fill and drop in_ready
            holds_served++;
            stall_left = LONG_HOLD - 1;
            out_ready <= 1'b0;
        end
        else if (rx_idle_en && $urandom_range(0, 99) < 25)
        begin
            stall_left = pick_gap() - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // result checker: every output beat against the oldest owed sample
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : check_output
        filt_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_filtered.size() == 0)
            begin
                errors++;
                $display("%0t: output beat with nothing owed, expected none actual %0d/%0b",
                         $time, sample_out, clipped);
            end
            else
            begin
                want = pending_filtered.pop_front();
                results_seen++;
                if (want.clip)
                    clips_seen++;
                if (sample_out !== want.sample)
                begin
                    errors++;
                    $display("%0t: sample_out mismatch, expected %0d actual %0d",
                             $time, want.sample, sample_out);
                end
                if (clipped !== want.clip)
                begin
                    errors++;
                    $display("%0t: clipped mismatch, expected %0b actual %0b",
                             $time, want.clip, clipped);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // shared driver tasks, all entered right after a rising edge
    // ------------------------------------------------------------------

    // offer one sample, hold it until the beat is taken, then maybe idle
    task automatic send_sample(input logic signed [SW-1:0] x);
        int gap;
        in_valid  <= 1'b1;
        sample_in <= x;
        do
            @(posedge clk);
        while (!in_ready);
        pending_filtered.push_back(notch_step(x));
        samples_sent++;
        gap = 0;
        if (tx_idle_en && $urandom_range(0, 99) < 30)
            gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop offering and wait until every owed result is back and the
    // pipeline has settled
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_filtered.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 2) @(posedge clk);
    endtask

    // one register write, with we dropped again after it so writes never run together
    task automatic write_coef(input logic [CFG_INDEX_W-1:0] idx,
                              input logic signed [COEF_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        // unmapped index leaves the coefficients alone
        if (idx <= REG_DEN_FOUR)
            filt_coef[idx] = val;
        @(posedge clk);
    endtask

    task automatic load_coefs(input logic signed [COEF_W-1:0] outer, inner, center,
                              input logic signed [COEF_W-1:0] b1, b2, b3, b4);
        write_coef(REG_NUM_OUTER, outer);
        write_coef(REG_NUM_INNER, inner);
        write_coef(REG_NUM_CENTER, center);
        write_coef(REG_DEN_ONE, b1);
        write_coef(REG_DEN_TWO, b2);
        write_coef(REG_DEN_THREE, b3);
        write_coef(REG_DEN_FOUR, b4);
        coef_loads++;
    endtask

    task automatic load_defaults();
        load_coefs(NUM_OUTER_RST, NUM_INNER_RST, NUM_CENTER_RST,
                   DEN_ONE_RST, DEN_TWO_RST, DEN_THREE_RST, DEN_FOUR_RST);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset coefficients: full-scale impulses of both signs ring through
    // both delay lines
    task automatic test_default_impulse();
        send_sample(SAMPLE_MAX);
        repeat (3) send_sample('0);
        send_sample(SAMPLE_MIN);
        repeat (2) send_sample('0);
        wait_idle();
    endtask

    // a single outer tap of half a history lsb: odd outer-pair sums tie when
    // the sum is rounded to q.8, and 255 ties again on the way to an
    // integer; all ties go toward plus infinity
    task automatic test_rounding_ties();
        load_coefs(TIE_TAP, '0, '0, '0, '0, '0, '0);
        // dropped write to the unmapped index, the taps must not move
        write_coef(REG_UNUSED, COEF_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        send_sample(16'sd255);
        send_sample(-16'sd257);
        send_sample(SAMPLE_MIN);
        wait_idle();
    endtask

    // every register at both rails: the history saturates high and low and
    // the output clips with it
    task automatic test_saturation();
        load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        repeat (3) send_sample(SAMPLE_MAX);
        repeat (3) send_sample(SAMPLE_MIN);
        wait_idle();
        load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
        repeat (3) send_sample(SAMPLE_MAX);
        repeat (3) send_sample(SAMPLE_MIN);
        wait_idle();
    endtask

    // sink holds off for a long stretch while samples keep coming, so the
    // block fills and stalls its input; then the source pauses until
    // everything has drained and resumes with both sides idling
    task automatic test_backpressure();
        load_defaults();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        holds_asked++;
        repeat (40) send_sample(rand_sample());
        wait_idle();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (20) send_sample(rand_sample());
        wait_idle();
    endtask

    // phases of random samples under the reset taps, mild stable taps and
    // wild full-range taps, with idling on and off per phase
    task automatic test_random_stream();
        int style;
        for (int p = 0; p < PHASES; p++)
        begin
            style = p % 3;
            if (style == 0)
                load_defaults();
            else if (style == 1)
                // |b| sum stays at or below one half, so the loop settles
                load_coefs(COEF_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20)),
                           COEF_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20)),
                           COEF_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20)),
                           COEF_W'(int'($urandom_range(0, 1 << 18)) - (1 << 17)),
                           COEF_W'(int'($urandom_range(0, 1 << 18)) - (1 << 17)),
                           COEF_W'(int'($urandom_range(0, 1 << 18)) - (1 << 17)),
                           COEF_W'(int'($urandom_range(0, 1 << 18)) - (1 << 17)));
            else
                load_coefs(COEF_W'($urandom()), COEF_W'($urandom()), COEF_W'($urandom()),
                           COEF_W'($urandom()), COEF_W'($urandom()), COEF_W'($urandom()),
                           COEF_W'($urandom()));
            // first phase runs flat out on both sides
            tx_idle_en = (p != 0) && ($urandom_range(0, 3) != 0);
            rx_idle_en = (p != 0) && ($urandom_range(0, 3) != 0);
            repeat (PHASE_BEATS) send_sample(rand_sample());
            wait_idle();
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        notch_reset();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_impulse();
        test_rounding_ties();
        test_saturation();
        test_backpressure();
        test_random_stream();

        // drain and let the pipeline settle before the verdict
        wait_idle();
        repeat (10) @(posedge clk);

        $display("covered %0d samples over %0d coefficient loads, %0d results checked",
                 samples_sent, coef_loads, results_seen);
        $display("%0d clipped results, one long sink hold-off, %0d mismatches",
                 clips_seen, errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/iirn4_pkg.sv
hw/rtl/iir_notch_filter_4th_order_core.sv
dv/testbench.sv
